[design/sdsq_pkg.sv]
// ----------------------------------------------------------------------------
// sdsq_pkg
// Shared types and codes for the stable descending sort queue.
// ----------------------------------------------------------------------------
package sdsq_pkg;

   localparam int KEY_BITS  = 32;
   localparam int WORD_BITS = 32;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] STATUS_PUSHED  = 2'd0;
   localparam logic [1:0] STATUS_POPPED  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [1:0] STATUS_DROPPED = 2'd3;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic push;    // transfer inserts an entry (store not full)
      logic pop;     // transfer removes the head (store not empty)
      logic pinned;  // head entry is pinned
   } ctrl_type;

endpackage

[design/sdsq_if.sv]
// ----------------------------------------------------------------------------
// sdsq_if
// Request and response channels of the sort queue (valid/ready).
// ----------------------------------------------------------------------------
interface sdsq_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic signed [sdsq_pkg::KEY_BITS-1:0] score_key;
   logic [sdsq_pkg::WORD_BITS-1:0]      move_code;

   modport source (output valid, output op, output score_key, output move_code,
                   input ready);
   modport sink   (input valid, input op, input score_key, input move_code,
                   output ready);
endinterface

interface sdsq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic [sdsq_pkg::WORD_BITS-1:0]      out_move;
   logic signed [sdsq_pkg::KEY_BITS-1:0] out_score;

   modport source (output valid, output status, output out_move, output out_score,
                   input ready);
   modport sink   (input valid, input status, input out_move, input out_score,
                   output ready);
endinterface

[design/sdsq_cell.sv]
// ----------------------------------------------------------------------------
// sdsq_cell
// One slot of the insertion chain: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module sdsq_cell #(
   parameter int MOVE_BITS = 32,
   parameter int CNT_W     = 7,
   parameter int INDEX     = 0
) (
   input  logic                                 clock,
   input  sdsq_pkg::ctrl_type                   ctrl,
   input  logic [CNT_W-1:0]                     count,
   input  logic signed [sdsq_pkg::KEY_BITS-1:0] new_key,
   input  logic [MOVE_BITS-1:0]                 new_move,
   input  logic                                 left_keep,
   input  logic signed [sdsq_pkg::KEY_BITS-1:0] left_key,
   input  logic [MOVE_BITS-1:0]                 left_move,
   input  logic signed [sdsq_pkg::KEY_BITS-1:0] right_key,
   input  logic [MOVE_BITS-1:0]                 right_move,
   output logic                                 keep,
   output logic signed [sdsq_pkg::KEY_BITS-1:0] key_q,
   output logic [MOVE_BITS-1:0]                 move_q
);

   logic signed [sdsq_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [MOVE_BITS-1:0]                 move_ff, move_in;
   logic                                 occupied;
   logic                                 head_lock;

   assign occupied  = CNT_W'(INDEX) < count;
   assign head_lock = (INDEX == 0) && ctrl.pinned;
   // equal keys stay ahead of the new entry
   assign keep      = occupied && ((key_ff >= new_key) || head_lock);

   always_comb begin
      key_in  = key_ff;
      move_in = move_ff;
      if (ctrl.pop) begin
         key_in  = right_key;
         move_in = right_move;
      end else if (ctrl.push && !keep) begin
         if (left_keep) begin
            key_in  = new_key;
            move_in = new_move;
         end else begin
            key_in  = left_key;
            move_in = left_move;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      move_ff <= move_in;
   end

   assign key_q  = key_ff;
   assign move_q = move_ff;

endmodule

[design/stable_descending_sort_queue.sv]
// ----------------------------------------------------------------------------
// stable_descending_sort_queue
// Stable descending insertion queue built as a chain of compare cells.
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    op, score_key, move_code
//   rsp_if   out  valid/ready    status, out_move, out_score
//   csr_*    in   write enable   pin_first
//
// One transfer per cycle while req_if.ready is high: every cell compares
// against the broadcast key in parallel and updates from itself, the new entry or a neighbor.
// The response sits in an output register in the cycle after the request is accepted.
// req_if.ready is low only while a response waits and rsp_if.ready is low.
// Synchronous reset empties the store; cell contents need no reset.
// ----------------------------------------------------------------------------
module stable_descending_sort_queue #(
   parameter int CAPACITY  = 64,
   parameter int MOVE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   sdsq_req_if.sink    req_if,
   sdsq_rsp_if.source  rsp_if,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int KB    = sdsq_pkg::KEY_BITS;
   localparam int WB    = sdsq_pkg::WORD_BITS;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             pinned_ff, pinned_in;
   logic             pin_first_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   logic [WB-1:0]    out_move_ff, out_move_in;
   logic signed [KB-1:0] out_score_ff, out_score_in;

   logic                 accept;
   logic                 is_empty;
   logic                 is_full;
   sdsq_pkg::ctrl_type   ctrl;
   logic [MOVE_BITS-1:0] new_move;
   logic [WB-1:0]        head_move;

   logic                 cell_keep [CAPACITY];
   logic signed [KB-1:0] cell_key  [CAPACITY];
   logic [MOVE_BITS-1:0] cell_move [CAPACITY];

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign is_empty     = count_ff == '0;
   assign is_full      = count_ff == CNT_W'(CAPACITY);

   assign ctrl.push   = accept && (req_if.op == sdsq_pkg::OP_PUSH) && !is_full;
   assign ctrl.pop    = accept && (req_if.op == sdsq_pkg::OP_POP) && !is_empty;
   assign ctrl.pinned = pinned_ff;

   generate
      if (MOVE_BITS >= WB) begin : g_wide
         assign new_move  = MOVE_BITS'(req_if.move_code);
         assign head_move = cell_move[0][WB-1:0];
      end else begin : g_narrow
         assign new_move  = req_if.move_code[MOVE_BITS-1:0];
         assign head_move = WB'(cell_move[0]);
      end
   endgenerate

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic                 left_keep;
         logic signed [KB-1:0] left_key;
         logic [MOVE_BITS-1:0] left_move;
         logic signed [KB-1:0] right_key;
         logic [MOVE_BITS-1:0] right_move;

         if (i == 0) begin : g_first
            assign left_keep = 1'b0;
            assign left_key  = req_if.score_key;
            assign left_move = new_move;
         end else begin : g_link
            assign left_keep = cell_keep[i-1];
            assign left_key  = cell_key[i-1];
            assign left_move = cell_move[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign right_key  = cell_key[i];
            assign right_move = cell_move[i];
         end else begin : g_next
            assign right_key  = cell_key[i+1];
            assign right_move = cell_move[i+1];
         end

         sdsq_cell #(
            .MOVE_BITS (MOVE_BITS),
            .CNT_W     (CNT_W),
            .INDEX     (i)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .count      (count_ff),
            .new_key    (req_if.score_key),
            .new_move   (new_move),
            .left_keep  (left_keep),
            .left_key   (left_key),
            .left_move  (left_move),
            .right_key  (right_key),
            .right_move (right_move),
            .keep       (cell_keep[i]),
            .key_q      (cell_key[i]),
            .move_q     (cell_move[i])
         );
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      pinned_in    = pinned_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      out_move_in  = out_move_ff;
      out_score_in = out_score_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_move_in  = '0;
         out_score_in = '0;
         if (req_if.op == sdsq_pkg::OP_PUSH) begin
            if (is_full) begin
               status_in = sdsq_pkg::STATUS_DROPPED;
            end else begin
               status_in = sdsq_pkg::STATUS_PUSHED;
               count_in  = count_ff + 1'b1;
               if (is_empty) begin
                  pinned_in = pin_first_ff;
               end
            end
         end else begin
            if (is_empty) begin
               status_in = sdsq_pkg::STATUS_EMPTY;
            end else begin
               status_in    = sdsq_pkg::STATUS_POPPED;
               count_in     = count_ff - 1'b1;
               pinned_in    = 1'b0;
               out_move_in  = head_move;
               out_score_in = cell_key[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pinned_ff    <= 1'b0;
         pin_first_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pinned_ff    <= pinned_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            pin_first_ff <= csr_write_data;
         end
      end
      status_ff    <= status_in;
      out_move_ff  <= out_move_in;
      out_score_ff <= out_score_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = status_ff;
   assign rsp_if.out_move  = out_move_ff;
   assign rsp_if.out_score = out_score_ff;

endmodule
